@@ hdl/cli_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_pkg: shared types and constants of the cubic Lagrange interpolator
// Fixed-point widths, lane and pipeline geometry, saturation limits and the
// reciprocal used for the final divide by six.
// ----------------------------------------------------------------------------
package cli_pkg;

    // Fraction bits of the position input
    localparam int FRAC_BITS = 15;

    // Payload widths
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 17;

    // One lane per sample, each lane multiplies three position factors
    localparam int LANES   = 4;
    localparam int FACTORS = 3;

    // t - k*S for k in 0..3, signed
    localparam int DIFF_W   = ((FRAC_BITS + 2 > POS_W) ? FRAC_BITS + 2 : POS_W) + 1;
    // sample times -3, -1, 1 or 3
    localparam int COEF_W   = SAMPLE_W + 2;
    localparam int PAIR_W   = 2 * DIFF_W;
    localparam int SPLIT_W  = DIFF_W;
    localparam int TRIPLE_W = DIFF_W + COEF_W;
    localparam int LO_W     = SPLIT_W + 1 + TRIPLE_W;
    localparam int HI_W     = PAIR_W - SPLIT_W + TRIPLE_W;
    localparam int PROD_W   = PAIR_W + TRIPLE_W;
    localparam int SUM_W    = PROD_W + 2;

    // Scaling by S^3, then the divide by six
    localparam int SHIFT    = 3 * FRAC_BITS;
    localparam int SCALED_W = SUM_W - SHIFT;

    // Smallest scaled magnitudes that overflow the positive / negative range
    localparam int SAT_POS_LIMIT = 6 * 32768;
    localparam int SAT_NEG_LIMIT = 6 * 32769;

    // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT, exact for x below 2^17
    localparam int DIV3_W     = 17;
    localparam int DIV3_SHIFT = 18;
    localparam int DIV3_MUL   = ((1 << DIV3_SHIFT) + 2) / 3;
    localparam int QPROD_W    = DIV3_W + DIV3_SHIFT;

    localparam logic [SAMPLE_W-1:0] VALUE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] VALUE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

    // Pipeline geometry: front stage, lane stages, merge stages
    localparam int LANE_STAGES  = 4;
    localparam int MERGE_STAGES = 4;
    localparam int PIPE_DEPTH   = 1 + LANE_STAGES + MERGE_STAGES;

    // Output queue
    localparam int OUT_PTR_W = 4;
    localparam int OUT_DEPTH = 1 << OUT_PTR_W;
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                clipped;
    } result_beat_t;

endpackage

@@ hdl/cli_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_req_if: request channel of the interpolator
// Four signed samples and a fixed-point position, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cli_req_if import cli_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample0;
    logic signed [SAMPLE_W-1:0] sample1;
    logic signed [SAMPLE_W-1:0] sample2;
    logic signed [SAMPLE_W-1:0] sample3;
    logic        [POS_W-1:0]    position;

    modport source (
        output valid, sample0, sample1, sample2, sample3, position,
        input  ready
    );

    modport sink (
        input  valid, sample0, sample1, sample2, sample3, position,
        output ready
    );

endinterface

@@ hdl/cli_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_rsp_if: result channel of the interpolator
// Interpolated sample and saturation flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cli_rsp_if import cli_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] value;
    logic                       clipped;

    modport source (
        output valid, value, clipped,
        input  ready
    );

    modport sink (
        input  valid, value, clipped,
        output ready
    );

endinterface

@@ hdl/cli_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_lane: one product lane
// Forms f1 * f2 * f3 * coef_sample over four register stages; the last wide
// product is cut into a low and a high partial product.
// ----------------------------------------------------------------------------
module cli_lane import cli_pkg::*; (
    input  logic  clk,
    input  diff_t f1,
    input  diff_t f2,
    input  diff_t f3,
    input  coef_t coef_sample,
    output prod_t product
);

    logic signed [PAIR_W-1:0]   pair_reg,   pair_next;
    diff_t                      f3_reg;
    coef_t                      coef_reg;
    logic signed [PAIR_W-1:0]   pair_d_reg;
    logic signed [TRIPLE_W-1:0] triple_reg, triple_next;
    logic signed [LO_W-1:0]     lo_reg,     lo_next;
    logic signed [HI_W-1:0]     hi_reg,     hi_next;
    prod_t                      prod_reg,   prod_next;

    // Stage 1: first pair of position factors
    assign pair_next = PAIR_W'(f1) * PAIR_W'(f2);

    // Stage 2: third factor times the weighted sample
    assign triple_next = TRIPLE_W'(f3_reg) * TRIPLE_W'(coef_reg);

    // Stage 3: partial products on the low and high halves of the pair
    assign lo_next = LO_W'($signed({1'b0, pair_d_reg[SPLIT_W-1:0]})) * LO_W'(triple_reg);
    assign hi_next = HI_W'($signed(pair_d_reg[PAIR_W-1:SPLIT_W])) * HI_W'(triple_reg);

    // Stage 4: recombine the partial products
    assign prod_next = (PROD_W'(hi_reg) <<< SPLIT_W) + PROD_W'(lo_reg);

    always_ff @(posedge clk)
    begin
        pair_reg   <= pair_next;
        f3_reg     <= f3;
        coef_reg   <= coef_sample;
        triple_reg <= triple_next;
        pair_d_reg <= pair_reg;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        prod_reg   <= prod_next;
    end

    assign product = prod_reg;

endmodule

@@ hdl/cli_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_merge: lane merge, scaling and saturation
// Adds the four lane products through a registered tree, divides by 6*S^3
// with truncation toward zero and clamps to the 16-bit sample range.
// ----------------------------------------------------------------------------
module cli_merge import cli_pkg::*; (
    input  logic         clk,
    input  prod_t        product [LANES],
    output result_beat_t beat
);

    sum_t                sum_a_reg, sum_a_next;
    sum_t                sum_b_reg, sum_b_next;
    sum_t                acc_reg,   acc_next;
    logic                neg_reg,   neg_next;
    logic                clip_reg,  clip_next;
    logic [DIV3_W-1:0]   half_reg,  half_next;
    result_beat_t        beat_reg,  beat_next;
    logic [SUM_W-1:0]    mag;
    logic [SCALED_W-1:0] scaled;
    logic [QPROD_W-1:0]  quot_prod;
    logic [SAMPLE_W-1:0] quot;

    // Stage 1 and 2: adder tree
    assign sum_a_next = SUM_W'(product[0]) + SUM_W'(product[1]);
    assign sum_b_next = SUM_W'(product[2]) + SUM_W'(product[3]);
    assign acc_next   = sum_a_reg + sum_b_reg;

    // Stage 3: magnitude, drop the S^3 scale, range check
    always_comb
    begin
        neg_next  = acc_reg[SUM_W-1];
        mag       = neg_next ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
        scaled    = mag[SUM_W-1:SHIFT];
        clip_next = neg_next ? (scaled >= SCALED_W'(SAT_NEG_LIMIT))
                             : (scaled >= SCALED_W'(SAT_POS_LIMIT));
        half_next = scaled[DIV3_W:1];
    end

    // Stage 4: divide by three via reciprocal, sign and clamp
    always_comb
    begin
        quot_prod = QPROD_W'(half_reg) * QPROD_W'(DIV3_MUL);
        quot      = quot_prod[DIV3_SHIFT +: SAMPLE_W];
        if (clip_reg)
        begin
            beat_next.value = neg_reg ? VALUE_MIN : VALUE_MAX;
        end
        else
        begin
            beat_next.value = neg_reg ? (SAMPLE_W'(0) - quot) : quot;
        end
        beat_next.clipped = clip_reg;
    end

    always_ff @(posedge clk)
    begin
        sum_a_reg <= sum_a_next;
        sum_b_reg <= sum_b_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        clip_reg  <= clip_next;
        half_reg  <= half_next;
        beat_reg  <= beat_next;
    end

    assign beat = beat_reg;

endmodule

@@ hdl/cli_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_out_fifo: result queue
// Holds finished beats until the consumer takes them; admission upstream is
// credit based so a push never meets a full queue.
// ----------------------------------------------------------------------------
module cli_out_fifo import cli_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  result_beat_t push_beat,
    input  logic         pop,
    output logic         out_valid,
    output result_beat_t out_beat
);

    result_beat_t         store [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg,  count_next;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + OUT_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + OUT_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_beat;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_beat  = store[rd_ptr_reg];

endmodule

@@ hdl/cubic_lagrange_interpolator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_lagrange_interpolator_unit: four-point cubic Lagrange interpolator
// Evaluates the cubic through four samples at a fixed-point position.
// ----------------------------------------------------------------------------
// Takes one request beat per clock and returns one result beat for each, in
// order. A result is offered after its request passes the pipeline: one
// stage forms t, t-S, t-2S and t-3S, four parallel lanes each spend four
// stages on one basis product, and four merge stages add the lanes, remove
// the S^3 scale, divide by six (toward zero) and saturate. Results wait in a
// 16-beat queue; request ready is low only while 16 accepted requests have
// not yet been delivered, so with a consumer that takes every beat the rate
// is one item per clock. value is 32767 or -32768 with clipped set when the
// polynomial leaves the 16-bit range; positions above three extrapolate.
// ----------------------------------------------------------------------------
module cubic_lagrange_interpolator_unit import cli_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    cli_req_if.sink    request,
    cli_rsp_if.source  result
);

    logic                  req_take;
    logic                  rsp_take;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;

    diff_t                 pos_t;
    diff_t                 diff1;
    diff_t                 diff2;
    diff_t                 diff3;
    coef_t                 y0x, y1x, y2x, y3x;
    coef_t                 y1x3, y2x3;

    diff_t                 fac_reg  [LANES][FACTORS];
    diff_t                 fac_next [LANES][FACTORS];
    coef_t                 coef_reg  [LANES];
    coef_t                 coef_next [LANES];
    prod_t                 lane_prod [LANES];
    result_beat_t          merged;
    result_beat_t          head;

    // Handshakes and credit count
    assign req_take  = request.valid & request.ready;
    assign rsp_take  = result.valid & result.ready;
    assign occ_next  = occ_reg + CNT_W'(req_take) - CNT_W'(rsp_take);
    assign vld_next  = {vld_reg[PIPE_DEPTH-2:0], req_take};

    assign request.ready = (occ_reg < CNT_W'(OUT_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            vld_reg <= vld_next;
        end
    end

    // Front stage: node distances and weighted samples
    always_comb
    begin
        pos_t = DIFF_W'(request.position);
        diff1 = pos_t - (DIFF_W'(1) <<< FRAC_BITS);
        diff2 = pos_t - (DIFF_W'(2) <<< FRAC_BITS);
        diff3 = pos_t - (DIFF_W'(3) <<< FRAC_BITS);

        y0x  = COEF_W'(request.sample0);
        y1x  = COEF_W'(request.sample1);
        y2x  = COEF_W'(request.sample2);
        y3x  = COEF_W'(request.sample3);
        y1x3 = y1x + (y1x <<< 1);
        y2x3 = y2x + (y2x <<< 1);

        coef_next[0] = -y0x;
        coef_next[1] = y1x3;
        coef_next[2] = -y2x3;
        coef_next[3] = y3x;

        // each lane leaves out the factor of its own node
        fac_next[0][0] = diff1;
        fac_next[0][1] = diff2;
        fac_next[0][2] = diff3;
        fac_next[1][0] = pos_t;
        fac_next[1][1] = diff2;
        fac_next[1][2] = diff3;
        fac_next[2][0] = pos_t;
        fac_next[2][1] = diff1;
        fac_next[2][2] = diff3;
        fac_next[3][0] = pos_t;
        fac_next[3][1] = diff1;
        fac_next[3][2] = diff2;
    end

    always_ff @(posedge clk)
    begin
        fac_reg  <= fac_next;
        coef_reg <= coef_next;
    end

    // Basis product lanes
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        cli_lane u_lane (
            .clk         (clk),
            .f1          (fac_reg[k][0]),
            .f2          (fac_reg[k][1]),
            .f3          (fac_reg[k][2]),
            .coef_sample (coef_reg[k]),
            .product     (lane_prod[k])
        );
    end

    // Merge, scale and clamp
    cli_merge u_merge (
        .clk     (clk),
        .product (lane_prod),
        .beat    (merged)
    );

    // Result queue
    cli_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (vld_reg[PIPE_DEPTH-1]),
        .push_beat (merged),
        .pop       (rsp_take),
        .out_valid (result.valid),
        .out_beat  (head)
    );

    assign result.value   = head.value;
    assign result.clipped = head.clipped;

endmodule

@@ hdl/cli_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_checker: port-level checks of the interpolator
// Tracks outstanding requests and checks that no result is offered without
// one, that a stalled result holds, the clamp values and the admission limit.
// ----------------------------------------------------------------------------
module cli_checker import cli_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [SAMPLE_W-1:0] rsp_value,
    input logic                rsp_clipped
);

    logic [CNT_W-1:0] pend_reg, pend_next;

    // Requests accepted but not yet answered
    assign pend_next = pend_reg + CNT_W'(req_valid & req_ready)
                                - CNT_W'(rsp_valid & rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_clipped))
        else $error("result beat changed while stalled");

    // A clipped result sits at one of the two rails
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_clipped |-> rsp_value == VALUE_MAX || rsp_value == VALUE_MIN)
        else $error("clipped result not at a rail");

    // No result without an outstanding request
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != '0)
        else $error("result offered with nothing outstanding");

    // Request ready drops only at the credit limit
    a_ready_limit: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> pend_reg == CNT_W'(OUT_DEPTH))
        else $error("request stalled below the credit limit");

endmodule

bind cubic_lagrange_interpolator_unit cli_checker u_cli_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (request.valid),
    .req_ready   (request.ready),
    .rsp_valid   (result.valid),
    .rsp_ready   (result.ready),
    .rsp_value   (result.value),
    .rsp_clipped (result.clipped)
);

@@ verif/tb_cubic_lagrange_interpolator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubic_lagrange_interpolator_unit: self-checking bench for the interpolator
// Drives sample sets and positions into the request channel and works out the
// exact interpolated value of each one with wide integer arithmetic. Result
// beats are checked in order against it. Directed corner cases come first,
// then random traffic with idle bursts on both channels, a long consumer
// stall that backs up the pipeline, and a final run at full rate.
// ----------------------------------------------------------------------------
module tb_cubic_lagrange_interpolator_unit import cli_pkg::*; ();

    localparam int  NODE        = 1 << FRAC_BITS;
    localparam int  POS_TOP     = (1 << POS_W) - 1;
    localparam int  WATCHDOG    = 2000;
    localparam int  DRAIN_WAIT  = 4 * PIPE_DEPTH;
    localparam int  HOLD_CYCLES = 300;
    localparam int  MAX_REPORTS = 10;

    logic clk;
    logic rst_n;

    cli_req_if req_if ();
    cli_rsp_if rsp_if ();

    // Expected result beats, oldest first
    result_beat_t expected_values[$];

    int  mismatches;
    int  quiet_cycles;
    int  hold_left;
    int  stall_left;
    bit  sender_idle;
    bit  receiver_idle;

    cubic_lagrange_interpolator_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if),
        .result  (rsp_if)
    );

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Exact cubic through four samples at a fixed-point position
    function automatic result_beat_t lagrange_value(
        input logic signed [SAMPLE_W-1:0] y0,
        input logic signed [SAMPLE_W-1:0] y1,
        input logic signed [SAMPLE_W-1:0] y2,
        input logic signed [SAMPLE_W-1:0] y3,
        input logic [POS_W-1:0]           pos
    );
        logic signed [127:0] a0, a1, a2, a3;
        logic signed [127:0] t, s, d1, d2, d3;
        logic signed [127:0] acc, mag, q;
        logic                neg;
        result_beat_t        r;
        a0 = 128'(y0);
        a1 = 128'(y1);
        a2 = 128'(y2);
        a3 = 128'(y3);
        t  = '0;
        t[POS_W-1:0] = pos;
        s  = 128'(1) << FRAC_BITS;
        d1 = t - s;
        d2 = t - 2 * s;
        d3 = t - 3 * s;
        acc = -(a0 * d1 * d2 * d3) + 3 * a1 * t * d2 * d3
              - 3 * a2 * t * d1 * d3 + a3 * t * d1 * d2;
        neg = acc[127];
        mag = neg ? -acc : acc;
        // drop the S^3 scale, then divide by six; both truncate the magnitude
        q   = (mag >> SHIFT) / 6;
        r.clipped = 1'b0;
        if (neg)
        begin
            if (q > 32768)
            begin
                r.value   = VALUE_MIN;
                r.clipped = 1'b1;
            end
            else
            begin
                r.value = SAMPLE_W'(-q);
            end
        end
        else
        begin
            if (q > 32767)
            begin
                r.value   = VALUE_MAX;
                r.clipped = 1'b1;
            end
            else
            begin
                r.value = SAMPLE_W'(q);
            end
        end
        return r;
    endfunction

    // One request beat; returns at a falling edge with valid still high
    task automatic send_sample_set(input int y0, input int y1, input int y2, input int y3,
                                   input int pos);
        int gap;
        if (sender_idle && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid    = 1'b1;
        req_if.sample0  = y0[SAMPLE_W-1:0];
        req_if.sample1  = y1[SAMPLE_W-1:0];
        req_if.sample2  = y2[SAMPLE_W-1:0];
        req_if.sample3  = y3[SAMPLE_W-1:0];
        req_if.position = pos[POS_W-1:0];
        do
            @(posedge clk);
        while (!req_if.ready);
        expected_values.push_back(lagrange_value(req_if.sample0, req_if.sample1,
                                                 req_if.sample2, req_if.sample3,
                                                 req_if.position));
        @(negedge clk);
    endtask

    // Random beat: smooth waveforms, wild samples, positions past the last node
    task automatic send_random_set();
        int y[4];
        int pos;
        int shape;
        shape = $urandom_range(0, 9);
        if (shape < 6)
        begin
            y[0] = int'($urandom_range(0, 65535)) - 32768;
            for (int k = 1; k < 4; k++)
            begin
                y[k] = y[k-1] + int'($urandom_range(0, 16000)) - 8000;
                if (y[k] > 32767)
                    y[k] = 32767;
                if (y[k] < -32768)
                    y[k] = -32768;
            end
        end
        else
        begin
            for (int k = 0; k < 4; k++)
                y[k] = int'($urandom_range(0, 65535)) - 32768;
        end
        case ($urandom_range(0, 9))
            0:       pos = int'($urandom_range(0, 3)) * NODE;
            1:       pos = int'($urandom_range(3 * NODE + 1, POS_TOP));
            default: pos = int'($urandom_range(0, 3 * NODE));
        endcase
        send_sample_set(y[0], y[1], y[2], y[3], pos);
    endtask

    // Directed corner cases
    task automatic test_directed();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        // on the nodes the sample comes back unchanged
        send_sample_set(32767, -32768, 0, 1, 0);
        send_sample_set(32767, -32768, 0, 1, NODE);
        send_sample_set(32767, -32768, 0, 1, 2 * NODE);
        send_sample_set(32767, -32768, 0, 1, 3 * NODE);
        send_sample_set(1, 2, 3, -32768, 3 * NODE);
        // constant waveforms, including exactly the negative limit unclipped
        send_sample_set(0, 0, 0, 0, POS_TOP);
        send_sample_set(32767, 32767, 32767, 32767, NODE + NODE / 2);
        send_sample_set(-32768, -32768, -32768, -32768, NODE + NODE / 2);
        // overshoot between the nodes, both directions
        send_sample_set(-32768, 32767, 32767, -32768, NODE + NODE / 2);
        send_sample_set(32767, -32768, -32768, 32767, NODE + NODE / 2);
        // extrapolation beyond three
        send_sample_set(0, 0, 0, 32767, POS_TOP);
        send_sample_set(0, 0, 0, -32768, POS_TOP);
        send_sample_set(0, 0, 0, 100, POS_TOP);
        // truncation toward zero on small values
        send_sample_set(0, 1, 0, 0, NODE / 2);
        send_sample_set(0, -1, 0, 0, NODE / 2);
        // bit patterns on samples and position
        send_sample_set('h5555, 'hAAAA, 'h5555, 'hAAAA, 1);
        send_sample_set('hAAAA, 'h5555, 'hAAAA, 'h5555, 65535);
        send_sample_set('h00FF, 'hFF00, 'h0F0F, 'hF0F0, 65536);
        req_if.valid = 1'b0;
    endtask

    // Random traffic with idle bursts on both sides
    task automatic test_random_idle(input int count);
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        repeat (count) send_random_set();
        req_if.valid = 1'b0;
    endtask

    // Consumer holds off while requests keep coming, so the queue fills
    task automatic test_backpressure(input int count);
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        hold_left     = HOLD_CYCLES;
        repeat (count) send_random_set();
        req_if.valid = 1'b0;
    endtask

    // Full rate, no idling at all
    task automatic test_full_rate(input int count);
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        repeat (count) send_random_set();
        req_if.valid = 1'b0;
    endtask

    // Consumer ready: a pending long hold-off comes first, then random stall bursts
    initial
    begin
        rsp_if.ready = 1'b0;
        stall_left   = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_if.ready = 1'b0;
                hold_left    = hold_left - 1;
            end
            else if (stall_left > 0)
            begin
                rsp_if.ready = 1'b0;
                stall_left   = stall_left - 1;
            end
            else if (receiver_idle && $urandom_range(0, 5) == 0)
            begin
                rsp_if.ready = 1'b0;
                stall_left   = $urandom_range(0, 8);
            end
            else
            begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    // Result checker: each beat against the oldest expectation
    always @(posedge clk)
    begin
        result_beat_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_values.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected beat value=%0d clipped=%0b", $realtime,
                             rsp_if.value, rsp_if.clipped);
            end
            else
            begin
                want = expected_values.pop_front();
                if (rsp_if.value !== want.value || rsp_if.clipped !== want.clipped)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: mismatch value exp=%0d act=%0d clipped exp=%0b act=%0b",
                                 $realtime, $signed(want.value), rsp_if.value,
                                 want.clipped, rsp_if.clipped);
                end
            end
        end
    end

    // Watchdog on cycles with no beat accepted on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("** cubic_lagrange_interpolator_unit: FAILED **");
                $finish;
            end
        end
    end

    // Test sequence
    initial
    begin
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.sample0  = '0;
        req_if.sample1  = '0;
        req_if.sample2  = '0;
        req_if.sample3  = '0;
        req_if.position = '0;
        mismatches      = 0;
        quiet_cycles    = 0;
        hold_left       = 0;
        sender_idle     = 1'b0;
        receiver_idle   = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_idle(600);
        test_backpressure(80);
        test_full_rate(350);

        // drain, then allow for any stray beats
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && expected_values.size() == 0)
            $display("** cubic_lagrange_interpolator_unit: PASSED **");
        else
            $display("** cubic_lagrange_interpolator_unit: FAILED **");
        $finish;
    end

endmodule
